[src/consistent_hash_ring_router_core_defines.svh]
// ----------------------------------------------------------------------------
// Consistent-hash ring router: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_RING_ROUTER_CORE_DEFINES_SVH
`define CONSISTENT_HASH_RING_ROUTER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CHRR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CHRR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/chrr_pkg.sv]
// ----------------------------------------------------------------------------
// Consistent-hash ring router: package
// Constants, codes, controller/datapath interface types and the FNV-1a step.
// ----------------------------------------------------------------------------
`default_nettype none

package chrr_pkg;

  localparam int unsigned SlotCountDef = 16;
  localparam int unsigned RingDepthDef = 4096;

  localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME_LO = 64'h1B3;
  localparam int unsigned FNV_SHIFT    = 40;
  localparam logic [7:0]  SEP_CHAR     = 8'h23;
  localparam logic [7:0]  DIGIT_ZERO   = 8'h30;
  localparam logic [7:0]  RESULT_CAP   = 8'd16;
  localparam logic [8:0]  VNODES_RST   = 9'd150;
  localparam logic [8:0]  TEN          = 9'd10;
  localparam logic [8:0]  HUNDRED      = 9'd100;

  typedef enum logic [1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_REPLICA = 2'd1,
    CMD_ADD     = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOTHING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    DP_NOP, DP_FOLD, DP_PREP, DP_LB_KEY, DP_LB_VH, DP_LB_READ, DP_LB_STEP,
    DP_P_WRAP, DP_READ_P, DP_READ_LO, DP_EMIT_RD, DP_EMIT_NONE, DP_EMIT_SLOT,
    DP_EMIT_SLOT_NONE, DP_WALK, DP_FLUSH, DP_MARK, DP_VH_SEP, DP_VH_D2,
    DP_VH_D1, DP_VH_D0, DP_SET_OWNER, DP_SET_FULL, DP_SH_INIT, DP_SH_READ,
    DP_SH_WRITE, DP_INSERT, DP_ER_INIT, DP_ER_READ, DP_ER_WRITE, DP_ER_DONE,
    DP_NEXT_I
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic fill_zero;
    logic limit_zero;
    logic slot_bad;
    logic slot_present;
    logic lb_done;
    logic ring_full;
    logic hit;
    logic sh_more;
    logic er_more;
    logic walk_more;
    logic i_lt_vn;
    logic i_ge100;
    logic i_ge10;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [63:0] hash;
    logic [3:0]  owner;
  } ring_entry_t;

  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [63:0] v);
    logic [63:0] x;
    x = h ^ v;
    return (x << FNV_SHIFT) + (x * FNV_PRIME_LO);
  endfunction

endpackage

`default_nettype wire

[src/chrr_datapath.sv]
// ----------------------------------------------------------------------------
// Consistent-hash ring router: datapath
// Hash fold, ring memory, search, shift, walk registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module chrr_datapath #(
  parameter int unsigned SLOT_COUNT = chrr_pkg::SlotCountDef,
  parameter int unsigned RING_DEPTH = chrr_pkg::RingDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        in_cmd_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              in_last_i,
  input  wire logic [3:0]        in_slot_i,
  input  wire logic [4:0]        in_want_i,
  input  wire logic              cfg_we_i,
  input  wire logic [8:0]        cfg_data_i,
  input  wire chrr_pkg::dp_cmd_t dp_cmd_i,
  output chrr_pkg::dp_stat_t     dp_stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [3:0]             out_owner_o,
  output logic [1:0]             out_status_o,
  output logic                   out_last_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned SW = ((IW >= 4) ? IW : 4) + 1;
  localparam int unsigned PW = $clog2(SLOT_COUNT + 1);

  chrr_pkg::ring_entry_t mem [RING_DEPTH];
  chrr_pkg::ring_entry_t rd_q, wdata;
  logic                  re, we;
  logic [AW-1:0]         raddr, waddr;

  logic [63:0]           acc_q, key_q, vh_q, target_q, fold_in;
  chrr_pkg::cmd_e        cmd_q;
  logic [3:0]            slot_q, pend_owner_q;
  logic [4:0]            want_q, got_q, limit;
  logic [8:0]            vnodes_q, i_q;
  logic [2:0]            d2_q;
  logic [3:0]            d1_q, d0_q;
  logic [CW-1:0]         fill_q, lo_q, hi_q, k_q, j_q, mid, p_next;
  logic [AW-1:0]         p_q;
  logic [SLOT_COUNT-1:0] present_q;
  logic [PW-1:0]         pcnt_q;
  logic [15:0]           seen_q;
  logic                  pend_valid_q, full_q;
  logic                  out_valid_q, out_last_q, emit, e_last, new_owner;
  logic [3:0]            out_owner_q, e_owner;
  logic [1:0]            out_status_q;
  chrr_pkg::status_e     e_status;
  logic [SW-1:0]         slot_w;
  logic [IW-1:0]         slot_idx;
  logic [7:0]            w8, c8, m8;
  logic                  in_sign;

  always_comb begin
    in_sign  = in_byte_i[7];
    fold_in  = chrr_pkg::fnv_fold(acc_q, {{56{in_sign}}, in_byte_i});
    mid      = lo_q + ((hi_q - lo_q) >> 1);
    p_next   = CW'(p_q) + CW'(1);
    slot_w   = SW'(slot_q);
    slot_idx = slot_w[IW-1:0];
    w8       = 8'(want_q);
    c8       = 8'(pcnt_q);
    m8       = (w8 < c8) ? w8 : c8;
    if (m8 > chrr_pkg::RESULT_CAP) begin
      m8 = chrr_pkg::RESULT_CAP;
    end
    limit     = m8[4:0];
    new_owner = !seen_q[rd_q.owner];
  end

  always_comb begin
    dp_stat_o.cmd          = cmd_q;
    dp_stat_o.fill_zero    = (fill_q == '0);
    dp_stat_o.limit_zero   = (limit == '0);
    dp_stat_o.slot_bad     = (slot_w >= SW'(SLOT_COUNT));
    dp_stat_o.slot_present = present_q[slot_idx];
    dp_stat_o.lb_done      = (lo_q >= hi_q);
    dp_stat_o.ring_full    = (fill_q >= CW'(RING_DEPTH));
    dp_stat_o.hit          = (lo_q < fill_q) && (rd_q.hash == vh_q);
    dp_stat_o.sh_more      = (j_q > lo_q);
    dp_stat_o.er_more      = ((j_q + CW'(1)) < fill_q);
    dp_stat_o.walk_more    = (k_q < fill_q) && (got_q < limit);
    dp_stat_o.i_lt_vn      = (i_q < vnodes_q);
    dp_stat_o.i_ge100      = (i_q >= chrr_pkg::HUNDRED);
    dp_stat_o.i_ge10       = (i_q >= chrr_pkg::TEN);
    dp_stat_o.out_free     = !out_valid_q || out_ready_i;
  end

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = rd_q;
    case (dp_cmd_i.op)
      chrr_pkg::DP_LB_READ: begin
        re    = 1'b1;
        raddr = mid[AW-1:0];
      end
      chrr_pkg::DP_READ_P: begin
        re    = 1'b1;
        raddr = p_q;
      end
      chrr_pkg::DP_READ_LO: begin
        re    = 1'b1;
        raddr = lo_q[AW-1:0];
      end
      chrr_pkg::DP_SH_READ: begin
        re    = 1'b1;
        raddr = AW'(j_q - CW'(1));
      end
      chrr_pkg::DP_ER_READ: begin
        re    = 1'b1;
        raddr = AW'(j_q + CW'(1));
      end
      chrr_pkg::DP_SET_OWNER, chrr_pkg::DP_INSERT: begin
        we          = 1'b1;
        waddr       = lo_q[AW-1:0];
        wdata.hash  = vh_q;
        wdata.owner = slot_q;
      end
      chrr_pkg::DP_SH_WRITE, chrr_pkg::DP_ER_WRITE: begin
        we    = 1'b1;
        waddr = j_q[AW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    e_owner  = '0;
    e_status = chrr_pkg::ST_OK;
    e_last   = 1'b1;
    case (dp_cmd_i.op)
      chrr_pkg::DP_EMIT_RD: begin
        emit    = 1'b1;
        e_owner = rd_q.owner;
      end
      chrr_pkg::DP_EMIT_NONE: begin
        emit     = 1'b1;
        e_status = chrr_pkg::ST_NOTHING;
      end
      chrr_pkg::DP_EMIT_SLOT: begin
        emit     = 1'b1;
        e_owner  = slot_q;
        e_status = full_q ? chrr_pkg::ST_FULL : chrr_pkg::ST_OK;
      end
      chrr_pkg::DP_EMIT_SLOT_NONE: begin
        emit     = 1'b1;
        e_owner  = slot_q;
        e_status = chrr_pkg::ST_NOTHING;
      end
      chrr_pkg::DP_WALK: begin
        emit    = new_owner && pend_valid_q;
        e_owner = pend_owner_q;
        e_last  = 1'b0;
      end
      chrr_pkg::DP_FLUSH: begin
        emit     = 1'b1;
        e_owner  = pend_valid_q ? pend_owner_q : 4'd0;
        e_status = pend_valid_q ? chrr_pkg::ST_OK : chrr_pkg::ST_NOTHING;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= chrr_pkg::FNV_BASIS;
      fill_q      <= '0;
      present_q   <= '0;
      pcnt_q      <= '0;
      vnodes_q    <= chrr_pkg::VNODES_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vnodes_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (dp_cmd_i.op)
        chrr_pkg::DP_FOLD: begin
          acc_q <= in_last_i ? chrr_pkg::FNV_BASIS : fold_in;
        end
        chrr_pkg::DP_MARK: begin
          if (cmd_q == chrr_pkg::CMD_ADD) begin
            present_q[slot_idx] <= 1'b1;
            pcnt_q              <= pcnt_q + PW'(1);
          end else begin
            present_q[slot_idx] <= 1'b0;
            pcnt_q              <= pcnt_q - PW'(1);
          end
        end
        chrr_pkg::DP_INSERT:   fill_q <= fill_q + CW'(1);
        chrr_pkg::DP_ER_DONE:  fill_q <= fill_q - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_owner_q  <= e_owner;
      out_status_q <= e_status;
      out_last_q   <= e_last;
    end
    case (dp_cmd_i.op)
      chrr_pkg::DP_FOLD: begin
        if (in_last_i) begin
          key_q  <= fold_in;
          cmd_q  <= chrr_pkg::cmd_e'(in_cmd_i);
          slot_q <= in_slot_i;
          want_q <= in_want_i;
        end
      end
      chrr_pkg::DP_PREP: begin
        seen_q       <= '0;
        pend_valid_q <= 1'b0;
        got_q        <= '0;
        i_q          <= '0;
        d2_q         <= '0;
        d1_q         <= '0;
        d0_q         <= '0;
        full_q       <= 1'b0;
      end
      chrr_pkg::DP_LB_KEY: begin
        lo_q     <= '0;
        hi_q     <= fill_q;
        target_q <= key_q;
      end
      chrr_pkg::DP_LB_VH: begin
        lo_q     <= '0;
        hi_q     <= fill_q;
        target_q <= vh_q;
      end
      chrr_pkg::DP_LB_STEP: begin
        if (rd_q.hash < target_q) begin
          lo_q <= mid + CW'(1);
        end else begin
          hi_q <= mid;
        end
      end
      chrr_pkg::DP_P_WRAP: begin
        p_q <= (lo_q >= fill_q) ? '0 : lo_q[AW-1:0];
        k_q <= '0;
      end
      chrr_pkg::DP_WALK: begin
        if (new_owner) begin
          seen_q[rd_q.owner] <= 1'b1;
          got_q              <= got_q + 5'd1;
          pend_owner_q       <= rd_q.owner;
          pend_valid_q       <= 1'b1;
        end
        p_q <= (p_next >= fill_q) ? '0 : p_next[AW-1:0];
        k_q <= k_q + CW'(1);
      end
      chrr_pkg::DP_VH_SEP: vh_q <= chrr_pkg::fnv_fold(key_q, 64'(chrr_pkg::SEP_CHAR));
      chrr_pkg::DP_VH_D2:
        vh_q <= chrr_pkg::fnv_fold(vh_q, 64'(chrr_pkg::DIGIT_ZERO + 8'(d2_q)));
      chrr_pkg::DP_VH_D1:
        vh_q <= chrr_pkg::fnv_fold(vh_q, 64'(chrr_pkg::DIGIT_ZERO + 8'(d1_q)));
      chrr_pkg::DP_VH_D0:
        vh_q <= chrr_pkg::fnv_fold(vh_q, 64'(chrr_pkg::DIGIT_ZERO + 8'(d0_q)));
      chrr_pkg::DP_SET_FULL: full_q <= 1'b1;
      chrr_pkg::DP_SH_INIT:  j_q <= fill_q;
      chrr_pkg::DP_SH_WRITE: j_q <= j_q - CW'(1);
      chrr_pkg::DP_ER_INIT:  j_q <= lo_q;
      chrr_pkg::DP_ER_WRITE: j_q <= j_q + CW'(1);
      chrr_pkg::DP_NEXT_I: begin
        i_q <= i_q + 9'd1;
        if (d0_q == 4'd9) begin
          d0_q <= '0;
          if (d1_q == 4'd9) begin
            d1_q <= '0;
            d2_q <= d2_q + 3'd1;
          end else begin
            d1_q <= d1_q + 4'd1;
          end
        end else begin
          d0_q <= d0_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_owner_o  = out_owner_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

[src/chrr_ctrl.sv]
// ----------------------------------------------------------------------------
// Consistent-hash ring router: controller
// Sequences byte folding, ring search, insert/erase shifts and replica walks.
// ----------------------------------------------------------------------------
`default_nettype none

module chrr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  input  wire chrr_pkg::dp_stat_t dp_stat_i,
  output chrr_pkg::dp_cmd_t       dp_cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_MARK, S_VLOOP, S_VH_D2, S_VH_D1, S_VH_D0, S_LB_KEY,
    S_LB_VH, S_LB_RD, S_LB_EV, S_LB_END, S_LU_RD, S_LU_EMIT, S_RP_CHK, S_RP_EV,
    S_RP_FLUSH, S_EMIT_NONE, S_EMIT_SLOT_NONE, S_VP_EV, S_SH_RD, S_SH_WR,
    S_ER_RD, S_ER_WR, S_NEXT_I, S_FIN
  } state_e;

  state_e           state_q, state_d;
  chrr_pkg::dp_op_e op;
  logic             lu;

  always_comb begin
    state_d    = state_q;
    op         = chrr_pkg::DP_NOP;
    in_ready_o = 1'b0;
    lu = (dp_stat_i.cmd == chrr_pkg::CMD_LOOKUP) || (dp_stat_i.cmd == chrr_pkg::CMD_REPLICA);
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op = chrr_pkg::DP_FOLD;
          if (in_last_i) state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        op = chrr_pkg::DP_PREP;
        case (dp_stat_i.cmd)
          chrr_pkg::CMD_LOOKUP:
            state_d = dp_stat_i.fill_zero ? S_EMIT_NONE : S_LB_KEY;
          chrr_pkg::CMD_REPLICA:
            state_d = (dp_stat_i.fill_zero || dp_stat_i.limit_zero) ? S_EMIT_NONE : S_LB_KEY;
          chrr_pkg::CMD_ADD:
            state_d = (dp_stat_i.slot_bad || dp_stat_i.slot_present) ?
                      S_EMIT_SLOT_NONE : S_MARK;
          default:
            state_d = (dp_stat_i.slot_bad || !dp_stat_i.slot_present) ?
                      S_EMIT_SLOT_NONE : S_MARK;
        endcase
      end
      S_MARK: begin
        op      = chrr_pkg::DP_MARK;
        state_d = S_VLOOP;
      end
      S_VLOOP: begin
        if (dp_stat_i.i_lt_vn) begin
          op      = chrr_pkg::DP_VH_SEP;
          state_d = S_VH_D2;
        end else begin
          state_d = S_FIN;
        end
      end
      S_VH_D2: begin
        if (dp_stat_i.i_ge100) op = chrr_pkg::DP_VH_D2;
        state_d = S_VH_D1;
      end
      S_VH_D1: begin
        if (dp_stat_i.i_ge10) op = chrr_pkg::DP_VH_D1;
        state_d = S_VH_D0;
      end
      S_VH_D0: begin
        op      = chrr_pkg::DP_VH_D0;
        state_d = S_LB_VH;
      end
      S_LB_KEY: begin
        op      = chrr_pkg::DP_LB_KEY;
        state_d = S_LB_RD;
      end
      S_LB_VH: begin
        op      = chrr_pkg::DP_LB_VH;
        state_d = S_LB_RD;
      end
      S_LB_RD: begin
        if (dp_stat_i.lb_done) begin
          state_d = S_LB_END;
        end else begin
          op      = chrr_pkg::DP_LB_READ;
          state_d = S_LB_EV;
        end
      end
      S_LB_EV: begin
        op      = chrr_pkg::DP_LB_STEP;
        state_d = S_LB_RD;
      end
      S_LB_END: begin
        if (lu) begin
          op      = chrr_pkg::DP_P_WRAP;
          state_d = (dp_stat_i.cmd == chrr_pkg::CMD_LOOKUP) ? S_LU_RD : S_RP_CHK;
        end else begin
          op      = chrr_pkg::DP_READ_LO;
          state_d = S_VP_EV;
        end
      end
      S_LU_RD: begin
        op      = chrr_pkg::DP_READ_P;
        state_d = S_LU_EMIT;
      end
      S_LU_EMIT: begin
        if (dp_stat_i.out_free) begin
          op      = chrr_pkg::DP_EMIT_RD;
          state_d = S_IDLE;
        end
      end
      S_RP_CHK: begin
        if (dp_stat_i.walk_more) begin
          op      = chrr_pkg::DP_READ_P;
          state_d = S_RP_EV;
        end else begin
          state_d = S_RP_FLUSH;
        end
      end
      S_RP_EV: begin
        if (dp_stat_i.out_free) begin
          op      = chrr_pkg::DP_WALK;
          state_d = S_RP_CHK;
        end
      end
      S_RP_FLUSH: begin
        if (dp_stat_i.out_free) begin
          op      = chrr_pkg::DP_FLUSH;
          state_d = S_IDLE;
        end
      end
      S_EMIT_NONE: begin
        if (dp_stat_i.out_free) begin
          op      = chrr_pkg::DP_EMIT_NONE;
          state_d = S_IDLE;
        end
      end
      S_EMIT_SLOT_NONE: begin
        if (dp_stat_i.out_free) begin
          op      = chrr_pkg::DP_EMIT_SLOT_NONE;
          state_d = S_IDLE;
        end
      end
      S_VP_EV: begin
        if (dp_stat_i.cmd == chrr_pkg::CMD_ADD) begin
          if (dp_stat_i.hit) begin
            op      = chrr_pkg::DP_SET_OWNER;
            state_d = S_NEXT_I;
          end else if (dp_stat_i.ring_full) begin
            op      = chrr_pkg::DP_SET_FULL;
            state_d = S_NEXT_I;
          end else begin
            op      = chrr_pkg::DP_SH_INIT;
            state_d = S_SH_RD;
          end
        end else if (dp_stat_i.hit) begin
          op      = chrr_pkg::DP_ER_INIT;
          state_d = S_ER_RD;
        end else begin
          state_d = S_NEXT_I;
        end
      end
      S_SH_RD: begin
        if (dp_stat_i.sh_more) begin
          op      = chrr_pkg::DP_SH_READ;
          state_d = S_SH_WR;
        end else begin
          op      = chrr_pkg::DP_INSERT;
          state_d = S_NEXT_I;
        end
      end
      S_SH_WR: begin
        op      = chrr_pkg::DP_SH_WRITE;
        state_d = S_SH_RD;
      end
      S_ER_RD: begin
        if (dp_stat_i.er_more) begin
          op      = chrr_pkg::DP_ER_READ;
          state_d = S_ER_WR;
        end else begin
          op      = chrr_pkg::DP_ER_DONE;
          state_d = S_NEXT_I;
        end
      end
      S_ER_WR: begin
        op      = chrr_pkg::DP_ER_WRITE;
        state_d = S_ER_RD;
      end
      S_NEXT_I: begin
        op      = chrr_pkg::DP_NEXT_I;
        state_d = S_VLOOP;
      end
      S_FIN: begin
        if (dp_stat_i.out_free) begin
          op      = chrr_pkg::DP_EMIT_SLOT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    dp_cmd_o.op = op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/consistent_hash_ring_router_core.sv]
// ----------------------------------------------------------------------------
// Consistent-hash ring router core
// FNV-1a keyed ring of virtual nodes with add, remove, lookup and replica walk.
// ----------------------------------------------------------------------------
// Key and name bytes are taken one beat per cycle while idle. A lookup is a
// binary search of the single-port ring memory, one read per probe; a replica
// lookup then walks ring entries, held while the result register is full. An
// add or remove hashes each virtual point, searches for it, and shifts the
// ring entries above it to open or close the gap, so it scales with
// vnodes_per_node times the number of points above it.
// One operation runs at a time; input is held off until the last result is
// registered, and a registered result stage lets the next key stream in.
`default_nettype none
`include "consistent_hash_ring_router_core_defines.svh"

module consistent_hash_ring_router_core #(
  parameter int unsigned SLOT_COUNT = chrr_pkg::SlotCountDef,
  parameter int unsigned RING_DEPTH = chrr_pkg::RingDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // data_byte, node_slot, replica_count, pad
  input  wire logic [1:0]  s_axis_tuser_i,  // command
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // owner_slot, pad
  output logic [1:0]       m_axis_tuser_o,  // status
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [8:0]  cfg_data_i       // vnodes_per_node
);

  chrr_pkg::dp_cmd_t  dp_cmd;
  chrr_pkg::dp_stat_t dp_stat;
  logic [3:0]         owner;
  logic               in_beat, fold_op, insert_op, emit_op;

  assign cfg_ready_o = 1'b1;

  chrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .dp_stat_i  (dp_stat),
    .dp_cmd_o   (dp_cmd)
  );

  chrr_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (s_axis_tuser_i),
    .in_byte_i    (s_axis_tdata_i[7:0]),
    .in_last_i    (s_axis_tlast_i),
    .in_slot_i    (s_axis_tdata_i[11:8]),
    .in_want_i    (s_axis_tdata_i[16:12]),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .dp_cmd_i     (dp_cmd),
    .dp_stat_o    (dp_stat),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_owner_o  (owner),
    .out_status_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, owner};

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign fold_op   = (dp_cmd.op == chrr_pkg::DP_FOLD);
  assign insert_op = (dp_cmd.op == chrr_pkg::DP_INSERT);
  assign emit_op   = dp_cmd.op inside {chrr_pkg::DP_EMIT_RD, chrr_pkg::DP_EMIT_NONE,
                                       chrr_pkg::DP_EMIT_SLOT, chrr_pkg::DP_EMIT_SLOT_NONE,
                                       chrr_pkg::DP_WALK, chrr_pkg::DP_FLUSH};

  `CHRR_ASSERT_IMP(a_beat_folds, in_beat, fold_op, "accepted beat not folded")
  `CHRR_ASSERT_IMP(a_no_insert_full, dp_stat.ring_full, !insert_op, "insert into full ring")
  `CHRR_ASSERT_IMP(a_emit_free, emit_op, dp_stat.out_free, "result register overwritten")

endmodule

`default_nettype wire

[test/tb_consistent_hash_ring_router_core.sv]
// ----------------------------------------------------------------------------
// Testbench: consistent-hash ring router core
// Drives key and node-name streams with add, remove, lookup and replica
// commands, predicts every result from a ring model of its own and checks
// each result beat in order, under several vnode settings and idle profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_consistent_hash_ring_router_core;

  localparam logic [63:0] HASH_BASIS = 64'd14695981039346656037;
  localparam logic [63:0] HASH_MULT  = 64'd1099511628211;
  localparam logic [7:0]  HASH_SEP   = 8'h23;
  localparam int          NODES      = 16;
  localparam int          DEPTH      = 4096;
  localparam int          STALL_MAX  = 500000;

  typedef struct {
    chrr_pkg::cmd_e cmd;
    logic [7:0]     b;
    logic           last;
    logic [3:0]     slot;
    logic [4:0]     cnt;
  } beat_t;

  typedef struct {
    logic [3:0]        owner;
    chrr_pkg::status_e st;
    logic              last;
  } route_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;   // data_byte, node_slot, replica_count, pad
  logic [1:0]  s_axis_tuser_i = '0;   // command
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // owner_slot, pad
  logic [1:0]  m_axis_tuser_o;        // status
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i = '0;       // vnodes_per_node

  consistent_hash_ring_router_core u_dut (.*);

  always #2 clk_i = ~clk_i;

  // ring model
  logic [63:0] ring_h [DEPTH];
  logic [3:0]  ring_o [DEPTH];
  int          ring_n;
  logic        slot_up [NODES];
  int          vnodes;
  logic [63:0] acc;

  beat_t  pending_beats[$];
  route_t expected_routes[$];
  beat_t  cur;
  int     idle_in, idle_out;
  int     errors, n_ops, n_routes, stall;
  int     name_of [NODES];

  function automatic logic [63:0] fold(logic [63:0] h, logic [63:0] v);
    return (h ^ v) * HASH_MULT;
  endfunction

  function automatic logic [63:0] point_hash(logic [63:0] base, int i);
    logic [63:0] h;
    h = fold(base, 64'(HASH_SEP));
    if (i >= 100) h = fold(h, 64'(8'h30 + (i / 100) % 10));
    if (i >= 10) h = fold(h, 64'(8'h30 + (i / 10) % 10));
    return fold(h, 64'(8'h30 + i % 10));
  endfunction

  function automatic int seek(logic [63:0] h);
    int lo, hi, mid;
    lo = 0;
    hi = ring_n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (ring_h[mid] < h) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic place_point(logic [63:0] h, logic [3:0] owner);
    int p;
    p = seek(h);
    if (p < ring_n && ring_h[p] == h) begin
      ring_o[p] = owner;
      return 1'b1;
    end
    if (ring_n >= DEPTH) return 1'b0;
    for (int k = ring_n; k > p; k--) begin
      ring_h[k] = ring_h[k-1];
      ring_o[k] = ring_o[k-1];
    end
    ring_h[p] = h;
    ring_o[p] = owner;
    ring_n++;
    return 1'b1;
  endfunction

  function automatic void drop_point(logic [63:0] h);
    int p;
    p = seek(h);
    if (p >= ring_n || ring_h[p] != h) return;
    for (int k = p; k < ring_n - 1; k++) begin
      ring_h[k] = ring_h[k+1];
      ring_o[k] = ring_o[k+1];
    end
    ring_n--;
  endfunction

  function automatic void expect_route(logic [3:0] o, chrr_pkg::status_e s, logic l);
    route_t r;
    r.owner = o;
    r.st = s;
    r.last = l;
    expected_routes.insert(expected_routes.size(), r);
  endfunction

  function automatic void route_beat(beat_t bt);
    logic [63:0] h;
    logic        seen [NODES];
    logic        full;
    int          p, up, lim, got, first;
    h = fold(acc, {{56{bt.b[7]}}, bt.b});
    if (!bt.last) begin
      acc = h;
      return;
    end
    acc = HASH_BASIS;
    n_ops++;
    case (bt.cmd)
      chrr_pkg::CMD_LOOKUP: begin
        if (ring_n == 0) expect_route(4'd0, chrr_pkg::ST_NOTHING, 1'b1);
        else begin
          p = seek(h);
          if (p >= ring_n) p = 0;
          expect_route(ring_o[p], chrr_pkg::ST_OK, 1'b1);
        end
      end
      chrr_pkg::CMD_REPLICA: begin
        up = 0;
        foreach (slot_up[i]) if (slot_up[i]) up++;
        lim = (bt.cnt < up) ? bt.cnt : up;
        if (lim > 16) lim = 16;
        got = 0;
        if (ring_n != 0 && lim != 0) begin
          foreach (seen[i]) seen[i] = 1'b0;
          p = seek(h);
          if (p >= ring_n) p = 0;
          first = expected_routes.size();
          for (int k = 0; k < ring_n && got < lim; k++) begin
            if (!seen[ring_o[p]]) begin
              seen[ring_o[p]] = 1'b1;
              expect_route(ring_o[p], chrr_pkg::ST_OK, 1'b0);
              got++;
            end
            p = (p + 1 >= ring_n) ? 0 : p + 1;
          end
          if (got != 0) expected_routes[first + got - 1].last = 1'b1;
        end
        if (got == 0) expect_route(4'd0, chrr_pkg::ST_NOTHING, 1'b1);
      end
      chrr_pkg::CMD_ADD: begin
        if (slot_up[bt.slot]) expect_route(bt.slot, chrr_pkg::ST_NOTHING, 1'b1);
        else begin
          slot_up[bt.slot] = 1'b1;
          full = 1'b0;
          for (int i = 0; i < vnodes; i++)
            if (!place_point(point_hash(h, i), bt.slot)) full = 1'b1;
          expect_route(bt.slot, full ? chrr_pkg::ST_FULL : chrr_pkg::ST_OK, 1'b1);
        end
      end
      default: begin
        if (!slot_up[bt.slot]) expect_route(bt.slot, chrr_pkg::ST_NOTHING, 1'b1);
        else begin
          slot_up[bt.slot] = 1'b0;
          for (int i = 0; i < vnodes; i++) drop_point(point_hash(h, i));
          expect_route(bt.slot, chrr_pkg::ST_OK, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d, want %0d (route %0d)", what, got, want, n_routes);
    errors++;
  endtask

  // driver: advance the beat queue, predict on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) route_beat(cur);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= idle_in) begin
          cur = pending_beats.pop_front();
          s_axis_tdata_i <= {7'd0, cur.cnt, cur.slot, cur.b};
          s_axis_tuser_i <= cur.cmd;
          s_axis_tlast_i <= cur.last;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    route_t w;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_routes.size() == 0) begin
          report("unexpected beat", m_axis_tdata_o, 8'd0);
        end else begin
          w = expected_routes.pop_front();
          if (m_axis_tdata_o[3:0] !== w.owner) report("owner", m_axis_tdata_o[3:0], w.owner);
          if (m_axis_tuser_o !== w.st) report("status", m_axis_tuser_o, w.st);
          if (m_axis_tlast_o !== w.last) report("last", m_axis_tlast_o, w.last);
        end
        n_routes++;
      end
      m_axis_tready_i <= ($urandom_range(99) >= idle_out);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall <= 0;
    end else if (stall >= STALL_MAX) begin
      $display("tb_consistent_hash_ring_router_core: done, errors");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  task automatic push_beat(chrr_pkg::cmd_e c, logic [7:0] b, logic l, logic [3:0] s,
                           logic [4:0] n);
    beat_t bt;
    bt.cmd = c;
    bt.b = b;
    bt.last = l;
    bt.slot = s;
    bt.cnt = n;
    pending_beats.insert(pending_beats.size(), bt);
  endtask

  // key of random bytes; earlier beats carry noise in command and slot
  task automatic push_key(chrr_pkg::cmd_e c, int len, logic [3:0] s, logic [4:0] n);
    for (int i = 0; i < len; i++)
      push_beat(i == len - 1 ? c : chrr_pkg::cmd_e'($urandom_range(3)), 8'($urandom),
                i == len - 1, i == len - 1 ? s : 4'($urandom), n);
  endtask

  // node name: letter plus digit, shared names give colliding points
  task automatic push_name(chrr_pkg::cmd_e c, int id, logic [3:0] s);
    push_beat(chrr_pkg::cmd_e'($urandom_range(3)), 8'h61 + 8'(id), 1'b0, 4'($urandom),
              5'($urandom));
    push_beat(c, 8'h30 + 8'(id), 1'b1, s, 5'($urandom));
  endtask

  task automatic settle();
    wait (pending_beats.size() == 0 && !s_axis_tvalid_i && expected_routes.size() == 0);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic set_vnodes(logic [8:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    vnodes = v;
  endtask

  task automatic random_ops(int beats);
    int r, s;
    while (pending_beats.size() < beats) begin
      r = $urandom_range(99);
      s = $urandom_range(15);
      if (r < 40)
        push_key(chrr_pkg::CMD_LOOKUP, $urandom_range(1, 5), 4'($urandom), 5'($urandom));
      else if (r < 62)
        push_key(chrr_pkg::CMD_REPLICA, $urandom_range(1, 5), 4'($urandom),
                 5'($urandom_range(16)));
      else if (r < 82) begin
        if (name_of[s] < 0) name_of[s] = $urandom_range(7);
        push_name(chrr_pkg::CMD_ADD, name_of[s], 4'(s));
      end else begin
        push_name(chrr_pkg::CMD_REMOVE, name_of[s] < 0 ? $urandom_range(7) : name_of[s],
                  4'(s));
        if ($urandom_range(3) != 0) name_of[s] = -1;
      end
    end
    settle();
  endtask

  initial begin
    acc = HASH_BASIS;
    ring_n = 0;
    vnodes = 150;
    foreach (slot_up[i]) slot_up[i] = 1'b0;
    foreach (name_of[i]) name_of[i] = -1;
    errors = 0;
    n_ops = 0;
    n_routes = 0;
    stall = 0;
    idle_in = 15;
    idle_out = 60;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty ring, then reset vnode count, duplicates and absent slots
    push_beat(chrr_pkg::CMD_LOOKUP, 8'h00, 1'b1, 4'd0, 5'd0);
    push_beat(chrr_pkg::CMD_REPLICA, 8'hFF, 1'b1, 4'd15, 5'd16);
    push_beat(chrr_pkg::CMD_REMOVE, 8'h41, 1'b1, 4'd5, 5'd0);
    push_name(chrr_pkg::CMD_ADD, 0, 4'd0);
    push_name(chrr_pkg::CMD_ADD, 0, 4'd0);
    push_beat(chrr_pkg::CMD_ADD, 8'h80, 1'b0, 4'd15, 5'd31);
    push_beat(chrr_pkg::CMD_LOOKUP, 8'h7F, 1'b1, 4'd15, 5'd16);
    push_beat(chrr_pkg::CMD_REPLICA, 8'h80, 1'b1, 4'd0, 5'd0);
    push_beat(chrr_pkg::CMD_REPLICA, 8'h01, 1'b1, 4'd0, 5'd16);
    push_name(chrr_pkg::CMD_REMOVE, 0, 4'd0);
    push_beat(chrr_pkg::CMD_LOOKUP, 8'hAA, 1'b1, 4'd0, 5'd0);
    settle();

    set_vnodes(9'd256);
    push_name(chrr_pkg::CMD_ADD, 1, 4'd1);
    push_beat(chrr_pkg::CMD_LOOKUP, 8'h55, 1'b1, 4'd0, 5'd0);
    push_name(chrr_pkg::CMD_REMOVE, 1, 4'd1);
    settle();

    // two slots under one name: every point of the second overwrites the first
    set_vnodes(9'd1);
    push_name(chrr_pkg::CMD_ADD, 2, 4'd2);
    push_name(chrr_pkg::CMD_ADD, 2, 4'd3);
    push_name(chrr_pkg::CMD_ADD, 3, 4'd15);
    push_beat(chrr_pkg::CMD_REPLICA, 8'h10, 1'b1, 4'd0, 5'd16);
    push_name(chrr_pkg::CMD_REMOVE, 2, 4'd2);
    push_beat(chrr_pkg::CMD_REPLICA, 8'h20, 1'b1, 4'd0, 5'd2);
    push_name(chrr_pkg::CMD_REMOVE, 3, 4'd15);
    settle();

    random_ops(82);
    set_vnodes(9'd7);
    idle_in = 60;
    idle_out = 15;
    random_ops(82);
    set_vnodes(9'd3);
    idle_in = 0;
    idle_out = 0;
    random_ops(82);

    $display("covered %0d operations, %0d result beats, vnode settings 150/256/1/7/3",
             n_ops, n_routes);
    if (errors == 0) begin
      $display("tb_consistent_hash_ring_router_core: done, clean");
    end else begin
      $display("tb_consistent_hash_ring_router_core: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
